// ----- hw/rtl/swhs_pkg.sv -----
// ----------------------------------------------------------------------------
// swhs_pkg
// Shared types and constants for the single-wire humidity sensor decoder.
// ----------------------------------------------------------------------------
package swhs_pkg;

    localparam int NUM_BYTES = 5;
    localparam logic [6:0] MAX_TRANSITIONS = 7'd85;
    localparam logic [5:0] FRAME_BITS = 6'd40;
    localparam logic [7:0] THRESH_RESET = 8'd16;
    localparam logic [7:0] TIMEOUT_RESET = 8'd255;
    localparam logic [16:0] DIV10_RECIP = 17'd52429;
    localparam int DIV10_SHIFT = 19;

    typedef enum logic [0:0] {
        REG_ONE_THRESHOLD = 1'b0,
        REG_TIMEOUT_LIMIT = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_GOOD  = 2'd0,
        ST_CSUM  = 2'd1,
        ST_SHORT = 2'd2
    } t_status;

    typedef struct packed {
        logic                          bits_ok;
        logic [NUM_BYTES-1:0][7:0]     bytes;
    } t_frame;

endpackage

// ----- hw/rtl/swhs_capture.sv -----
// ----------------------------------------------------------------------------
// swhs_capture
// Run-length measurement, transition counting and bit capture; latches the
// finished frame for conversion.
// ----------------------------------------------------------------------------
module swhs_capture (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [0:0]          i_cfg_idx,
    input  logic [7:0]          i_cfg_data,
    input  logic                i_valid,
    input  logic                i_start,
    input  logic                i_level,
    output logic                o_ready,
    input  logic                i_take,
    output logic                o_fin_vld,
    output swhs_pkg::t_frame    o_fin
);
    import swhs_pkg::*;

    logic [7:0]       r_thresh;
    logic [7:0]       r_timeout;
    logic             r_capturing, n_capturing;
    logic             r_prev, n_prev;
    logic [7:0]       r_run, n_run;
    logic [6:0]       r_tidx, n_tidx;
    logic [5:0]       r_bc, n_bc;
    logic [4:0][7:0]  r_bytes, n_bytes;
    logic             r_fin_vld;
    t_frame           r_fin;
    logic             fin_adv;
    logic             accept;
    logic             finish;
    logic [2:0]       byte_idx;

    assign fin_adv = !r_fin_vld || i_take;
    assign o_ready = fin_adv;
    assign accept  = i_valid && fin_adv;
    assign byte_idx = r_bc[5:3];

    always_comb begin
        n_capturing = r_capturing;
        n_prev      = r_prev;
        n_run       = r_run;
        n_tidx      = r_tidx;
        n_bc        = r_bc;
        n_bytes     = r_bytes;
        finish      = 1'b0;
        if (i_start) begin
            n_capturing = 1'b1;
            n_prev      = 1'b1;
            n_run       = '0;
            n_tidx      = '0;
            n_bc        = '0;
            n_bytes     = '0;
        end else if (r_capturing) begin
            if (i_level == r_prev) begin
                n_run  = r_run + 8'd1;
                finish = (n_run == r_timeout);
            end else begin
                if (r_tidx >= 7'd4 && !r_tidx[0] && r_bc < FRAME_BITS) begin
                    for (int k = 0; k < NUM_BYTES; k++) begin
                        if (byte_idx == 3'(k)) begin
                            n_bytes[k] = {r_bytes[k][6:0], (r_run > r_thresh)};
                        end
                    end
                    n_bc = r_bc + 6'd1;
                end
                n_prev = i_level;
                n_run  = '0;
                n_tidx = r_tidx + 7'd1;
                finish = (n_tidx >= MAX_TRANSITIONS);
            end
            if (finish) begin
                n_capturing = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh    <= THRESH_RESET;
            r_timeout   <= TIMEOUT_RESET;
            r_capturing <= 1'b0;
            r_prev      <= 1'b1;
            r_run       <= '0;
            r_tidx      <= '0;
            r_bc        <= '0;
            r_bytes     <= '0;
            r_fin_vld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_idx))
                    REG_ONE_THRESHOLD: r_thresh  <= i_cfg_data;
                    REG_TIMEOUT_LIMIT: r_timeout <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_capturing <= n_capturing;
                r_prev      <= n_prev;
                r_run       <= n_run;
                r_tidx      <= n_tidx;
                r_bc        <= n_bc;
                r_bytes     <= n_bytes;
            end
            if (fin_adv) begin
                r_fin_vld <= accept && finish;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && finish) begin
            r_fin.bits_ok <= (n_bc >= FRAME_BITS);
            r_fin.bytes   <= n_bytes;
        end
    end

    assign o_fin_vld = r_fin_vld;
    assign o_fin     = r_fin;

`ifndef SYNTH
    a_bc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bc <= FRAME_BITS)
        else $error("bit count beyond frame length");

    a_tidx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_capturing |-> r_tidx < MAX_TRANSITIONS)
        else $error("transition index past frame end while capturing");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_start |=> r_capturing && r_bc == '0 && r_tidx == '0)
        else $error("start request did not rearm capture");

    a_fin_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin_vld && !i_take |=> r_fin_vld && $stable(r_fin))
        else $error("pending frame lost while stalled");
`endif

endmodule

// ----- hw/rtl/swhs_convert.sv -----
// ----------------------------------------------------------------------------
// swhs_convert
// Frame check and conversion to tenths and whole units; result register.
// ----------------------------------------------------------------------------
module swhs_convert (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fin_vld,
    input  swhs_pkg::t_frame    i_fin,
    output logic                o_take,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [1:0]          o_status,
    output logic [15:0]         o_hum,
    output logic [15:0]         o_temp,
    output logic [12:0]         o_humw,
    output logic [12:0]         o_tempw
);
    import swhs_pkg::*;

    logic             out_load;
    logic             r_valid;
    t_status          r_status, n_status;
    logic [15:0]      r_hum, n_hum;
    logic [15:0]      r_temp, n_temp;
    logic [12:0]      r_humw, n_humw;
    logic [12:0]      r_tempw, n_tempw;
    logic [7:0]       csum;
    logic [15:0]      hum;
    logic [14:0]      mag;
    logic [32:0]      hum_prod;
    logic [31:0]      mag_prod;
    logic [12:0]      humw;
    logic [11:0]      magw;

    assign out_load = !r_valid || i_ready;
    assign o_take   = out_load;

    assign csum     = i_fin.bytes[0] + i_fin.bytes[1] + i_fin.bytes[2] + i_fin.bytes[3];
    assign hum      = {i_fin.bytes[0], i_fin.bytes[1]};
    assign mag      = {i_fin.bytes[2][6:0], i_fin.bytes[3]};
    assign hum_prod = hum * DIV10_RECIP;
    assign mag_prod = mag * DIV10_RECIP;
    assign humw     = hum_prod[DIV10_SHIFT +: 13];
    assign magw     = mag_prod[DIV10_SHIFT +: 12];

    always_comb begin
        n_status = ST_GOOD;
        n_hum    = '0;
        n_temp   = '0;
        n_humw   = '0;
        n_tempw  = '0;
        priority if (!i_fin.bits_ok) begin
            n_status = ST_SHORT;
        end else if (i_fin.bytes[4] != csum) begin
            n_status = ST_CSUM;
        end else begin
            n_hum  = hum;
            n_humw = humw;
            if (i_fin.bytes[2][7]) begin
                n_temp  = 16'd0 - {1'b0, mag};
                n_tempw = 13'd0 - {1'b0, magw};
            end else begin
                n_temp  = {1'b0, mag};
                n_tempw = {1'b0, magw};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (out_load) begin
            r_valid <= i_fin_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && i_fin_vld) begin
            r_status <= n_status;
            r_hum    <= n_hum;
            r_temp   <= n_temp;
            r_humw   <= n_humw;
            r_tempw  <= n_tempw;
        end
    end

    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_hum    = r_hum;
    assign o_temp   = r_temp;
    assign o_humw   = r_humw;
    assign o_tempw  = r_tempw;

`ifndef SYNTH
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_status != ST_GOOD |-> r_hum == '0 && r_temp == '0
            && r_humw == '0 && r_tempw == '0)
        else $error("bad frame carries nonzero values");

    a_load_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load && i_fin_vld |=> r_valid)
        else $error("finished frame not registered");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> r_valid && $stable(r_hum) && $stable(r_status))
        else $error("stalled result changed");
`endif

endmodule

// ----- hw/rtl/single_wire_humidity_sensor_decoder.sv -----
// ----------------------------------------------------------------------------
// single_wire_humidity_sensor_decoder
// Decodes a single-wire humidity and temperature sensor frame from per-tick
// line samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one request per microsecond tick; tuser is the start flag,
//   tdata bit 0 the sampled line level. A start request rearms the capture
//   and its level is ignored. Requests are taken one per cycle while o_s_tready is high.
//   Output stream: one result per finished frame (transition count reached
//   or a run hit timeout_limit). tuser carries status, tdata the values.
//   Path: the request that ends a frame is registered in the capture stage's
//   frame latch, then converted into the result register on the output.
//   Throughput: one request per cycle while o_s_tready is high; the frame latch
//   and the result register let capture keep running while a result waits.
//   Stall: while the result register and the frame latch are both full and
//   the receiver holds tready low, o_s_tready drops.
//   Reset: thresholds return to 16 and 255, capture is idle, no result.
//   Configuration writes take effect on the next cycle.
// ----------------------------------------------------------------------------
module single_wire_humidity_sensor_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [0] line_level, [7:1] zero
    input  logic        i_s_tuser,   // [0] start_req
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [15:0] humidity_tenths, [31:16] temperature_tenths,
                                     // [44:32] humidity_whole, [57:45] temperature_whole
    output logic [1:0]  o_m_tuser    // [1:0] status
);
    import swhs_pkg::*;

    logic        fin_vld;
    t_frame      fin;
    logic        take;
    logic [15:0] hum;
    logic [15:0] temp;
    logic [12:0] humw;
    logic [12:0] tempw;

    swhs_capture u_capture (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_s_tvalid),
        .i_start    (i_s_tuser),
        .i_level    (i_s_tdata[0]),
        .o_ready    (o_s_tready),
        .i_take     (take),
        .o_fin_vld  (fin_vld),
        .o_fin      (fin)
    );

    swhs_convert u_convert (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fin_vld (fin_vld),
        .i_fin     (fin),
        .o_take    (take),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_status  (o_m_tuser),
        .o_hum     (hum),
        .o_temp    (temp),
        .o_humw    (humw),
        .o_tempw   (tempw)
    );

    assign o_m_tdata = {6'd0, tempw, humw, temp, hum};

endmodule
